>>> rtl/core/sdepq_pkg.sv
// Shared types and codes for the sorted double-ended priority queue.
package sdepq_pkg;

    localparam int FILL_W = 5;

    localparam logic [1:0] CMD_INSERT     = 2'd0;
    localparam logic [1:0] CMD_REMOVE_MAX = 2'd1;
    localparam logic [1:0] CMD_REMOVE_MIN = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_EMPTY    = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_NULL_TAG = 2'd3;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [15:0] prio_in;
        logic [15:0]        tag_in;
    } in_item_t;

    typedef struct packed {
        logic [15:0]        tag_out;
        logic signed [15:0] prio_out;
        logic [1:0]         status;
        logic [FILL_W-1:0]  fill_level;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_PLACE,
        ST_DONE
    } sdepq_state_t;

    typedef struct packed {
        logic load_item;
        logic rd_last;
        logic rd_first;
        logic rd_prev;
        logic wr_shift;
        logic wr_new_above;
        logic wr_new_zero;
        logic res_load;
        logic cnt_inc;
        logic cnt_dec;
        logic head_inc;
    } dp_cmd_t;

    typedef struct packed {
        logic is_ins;
        logic is_max;
        logic is_min;
        logic tag_null;
        logic empty;
        logic full;
        logic shift;
        logic idx_zero;
    } dp_stat_t;

endpackage

>>> rtl/core/sdepq_dp.sv
// Datapath: entry ring memory, item and scan registers, counters, result register.
module sdepq_dp
    import sdepq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int PRIO_WIDTH = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_item_t  s_data,
    input  dp_cmd_t   cmd,
    output dp_stat_t  stat,
    output out_item_t m_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = PRIO_WIDTH;
    localparam int EW = PW + 16;

    logic [EW-1:0] mem [DEPTH];

    logic [1:0]          cmd_reg;
    logic signed [PW-1:0] prio_reg;
    logic [15:0]         tag_reg;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       head_reg, head_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic                first_reg, first_next;
    logic [EW-1:0]       rd_data_reg;
    out_item_t           res_reg;

    logic [PW+15:0]      prio_in_ext;
    logic [PW+15:0]      prio_out_ext;
    logic [FILL_W+CW-1:0] fill_ext;
    logic [CW-1:0]       count_m1;
    logic [AW-1:0]       last_idx, idx_p1, idx_m1;
    logic signed [PW-1:0] rd_prio;
    logic [15:0]         rd_tag;
    logic                rd_en, wr_en;
    logic [AW-1:0]       rd_addr, wr_addr;
    logic [EW-1:0]       wr_data, new_entry;
    logic                rem_ok;
    logic [1:0]          status;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [AW-1:0] i);
        logic [AW:0] sum;
        sum = {1'b0, h} + {1'b0, i};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign prio_in_ext = {{PW{s_data.prio_in[15]}}, s_data.prio_in};
    assign count_m1    = count_reg - 1'b1;
    assign last_idx    = count_m1[AW-1:0];
    assign idx_p1      = idx_reg + 1'b1;
    assign idx_m1      = idx_reg - 1'b1;
    assign rd_prio     = rd_data_reg[EW-1:16];
    assign rd_tag      = rd_data_reg[15:0];
    assign new_entry   = {prio_reg, tag_reg};

    assign stat.is_ins   = (cmd_reg == CMD_INSERT);
    assign stat.is_max   = (cmd_reg == CMD_REMOVE_MAX);
    assign stat.is_min   = (cmd_reg == CMD_REMOVE_MIN);
    assign stat.tag_null = (tag_reg == 16'd0);
    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg == CW'(DEPTH));
    assign stat.shift    = first_reg ? (rd_prio > prio_reg) : (rd_prio >= prio_reg);
    assign stat.idx_zero = (idx_reg == '0);

    assign rem_ok = (stat.is_max || stat.is_min) && !stat.empty;

    always_comb begin
        priority if (stat.is_ins && stat.tag_null) begin
            status = STAT_NULL_TAG;
        end else if (stat.is_ins && stat.full) begin
            status = STAT_FULL;
        end else if ((stat.is_max || stat.is_min) && stat.empty) begin
            status = STAT_EMPTY;
        end else begin
            status = STAT_OK;
        end
    end

    always_comb begin
        rd_en   = cmd.rd_last || cmd.rd_first || cmd.rd_prev;
        rd_addr = head_reg;
        if (cmd.rd_last) begin
            rd_addr = phys(head_reg, last_idx);
        end else if (cmd.rd_prev) begin
            rd_addr = phys(head_reg, idx_m1);
        end
    end

    always_comb begin
        wr_en   = cmd.wr_shift || cmd.wr_new_above || cmd.wr_new_zero;
        wr_addr = cmd.wr_new_zero ? head_reg : phys(head_reg, idx_p1);
        wr_data = cmd.wr_shift ? rd_data_reg : new_entry;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.cnt_inc) begin
            count_next = count_reg + 1'b1;
        end else if (cmd.cnt_dec) begin
            count_next = count_m1;
        end
        head_next  = cmd.head_inc ? phys(head_reg, AW'(1)) : head_reg;
        idx_next   = idx_reg;
        first_next = first_reg;
        if (cmd.rd_last) begin
            idx_next   = last_idx;
            first_next = 1'b1;
        end else if (cmd.rd_prev) begin
            idx_next   = idx_m1;
            first_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            head_reg  <= '0;
            first_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            head_reg  <= head_next;
            first_reg <= first_next;
        end
    end

    assign prio_out_ext = {{16{rd_prio[PW-1]}}, rd_prio};
    assign fill_ext     = {{FILL_W{1'b0}}, count_next};

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (cmd.load_item) begin
            cmd_reg  <= s_data.cmd;
            prio_reg <= prio_in_ext[PW-1:0];
            tag_reg  <= s_data.tag_in;
        end
        if (cmd.res_load) begin
            res_reg.tag_out    <= rem_ok ? rd_tag : 16'd0;
            res_reg.prio_out   <= rem_ok ? prio_out_ext[15:0] : 16'sd0;
            res_reg.status     <= status;
            res_reg.fill_level <= fill_ext[FILL_W-1:0];
        end
    end

    assign m_data = res_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_one_write: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.wr_shift, cmd.wr_new_above, cmd.wr_new_zero}))
        else $error("conflicting memory writes");

    a_head_with_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.head_inc |-> (cmd.cnt_dec && stat.is_min && !stat.empty))
        else $error("head advanced without a front removal");
`endif

endmodule

>>> rtl/core/sdepq_ctrl.sv
// Controller: sequences decode, insertion scan, removal and result handoff.
module sdepq_ctrl
    import sdepq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    sdepq_state_t state_reg, state_next;
    logic         m_valid_reg, m_valid_next;
    logic         ins_ok, rem_ok, stall;

    assign ins_ok = stat.is_ins && !stat.tag_null && !stat.full;
    assign rem_ok = (stat.is_max || stat.is_min) && !stat.empty;
    assign stall  = m_valid_reg && !m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (ins_ok && !stat.empty) begin
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN: begin
                if (!stat.shift) begin
                    state_next = ST_DONE;
                end else if (stat.idx_zero) begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!stall) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.load_item = s_valid;
            end
            ST_DECIDE: begin
                cmd.wr_new_zero = ins_ok && stat.empty;
                cmd.rd_last     = (ins_ok && !stat.empty) || (rem_ok && stat.is_max);
                cmd.rd_first    = rem_ok && stat.is_min;
            end
            ST_SCAN: begin
                cmd.wr_shift     = stat.shift;
                cmd.rd_prev      = stat.shift && !stat.idx_zero;
                cmd.wr_new_above = !stat.shift;
            end
            ST_PLACE: begin
                cmd.wr_new_zero = 1'b1;
            end
            ST_DONE: begin
                cmd.res_load = !stall;
                cmd.cnt_inc  = !stall && ins_ok;
                cmd.cnt_dec  = !stall && rem_ok;
                cmd.head_inc = !stall && rem_ok && stat.is_min;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.res_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

`ifndef NO_ASSERTIONS
    a_scan_only_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> stat.is_ins)
        else $error("scan entered for a removal");

    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_load |=> m_valid_reg)
        else $error("loaded result not presented");

    a_no_inc_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cnt_inc |-> (!stat.full && !cmd.cnt_dec))
        else $error("insert counted into a full queue");
`endif

endmodule

>>> rtl/core/sorted_double_ended_priority_queue_unit.sv
// Top level of the sorted double-ended priority queue.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid / s_ready  in_item_t  (cmd, prio_in, tag_in)
//   m_       out        m_valid / m_ready  out_item_t (tag_out, prio_out, status, fill_level)
//
// One transaction at a time. Removals, rejected inserts and inserts into an empty
// queue go from decode straight to the result; any other insert first scans the entry
// memory from the last entry down, moving entries up one per cycle until its slot is found.
// Entries live in a ring so front removal is a head advance.
// aresetn is synchronous and empties the queue; memory contents are not cleared.
// A result waiting on m_ready holds the next transaction in its final cycle.
module sorted_double_ended_priority_queue_unit
    import sdepq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int PRIO_WIDTH = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sdepq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    sdepq_dp #(
        .DEPTH      (DEPTH),
        .PRIO_WIDTH (PRIO_WIDTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_data  (m_data)
    );

endmodule

>>> tb/sorted_double_ended_priority_queue_unit_test.sv
// Self-checking testbench for the sorted double-ended priority queue unit.
`timescale 1ns / 100ps

module sorted_double_ended_priority_queue_unit_test;
    import sdepq_pkg::*;

    localparam int         QUEUE_DEPTH    = 16;
    localparam int         RANDOM_ITEMS   = 825;
    localparam int         LONG_HOLD      = 150;
    localparam int         TAIL_CYCLES    = 40;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam logic [1:0] CMD_UNUSED     = 2'd3;

    typedef struct packed {
        logic signed [15:0] prio;
        logic [15:0]        tag;
    } held_entry_t;

    typedef struct {
        in_item_t  stim;
        bit        typed;
        out_item_t want;
    } queue_row_t;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;
    logic      hold_request = 1'b0;

    held_entry_t held_entries[$];
    out_item_t   expected_results[$];
    queue_row_t  directed_rows[$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int error_count = 0;
    int sent_count = 0;
    int results_checked = 0;
    int full_rejects = 0;
    int empty_removes = 0;
    int null_tags = 0;
    int stall_cycles = 0;

    sorted_double_ended_priority_queue_unit #(
        .DEPTH      (QUEUE_DEPTH),
        .PRIO_WIDTH (16)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic out_item_t sorted_queue_step(input in_item_t op);
        out_item_t   r;
        held_entry_t e;
        int          pos;
        r = '0;
        case (op.cmd)
            CMD_INSERT: begin
                if (op.tag_in == 16'd0) begin
                    r.status = STAT_NULL_TAG;
                    null_tags++;
                end else if (held_entries.size() >= QUEUE_DEPTH) begin
                    r.status = STAT_FULL;
                    full_rejects++;
                end else begin
                    e.prio = op.prio_in;
                    e.tag  = op.tag_in;
                    pos = held_entries.size();
                    if (pos > 0 && op.prio_in < held_entries[pos-1].prio) begin
                        for (int i = 0; i < held_entries.size(); i++) begin
                            if (held_entries[i].prio >= op.prio_in) begin
                                pos = i;
                                break;
                            end
                        end
                    end
                    held_entries.insert(pos, e);
                end
            end
            CMD_REMOVE_MAX, CMD_REMOVE_MIN: begin
                if (held_entries.size() == 0) begin
                    r.status = STAT_EMPTY;
                    empty_removes++;
                end else begin
                    e = (op.cmd == CMD_REMOVE_MAX) ? held_entries.pop_back()
                                                   : held_entries.pop_front();
                    r.tag_out  = e.tag;
                    r.prio_out = e.prio;
                end
            end
            default: ;
        endcase
        r.fill_level = FILL_W'(held_entries.size());
        return r;
    endfunction

    function automatic in_item_t random_queue_op(input int insert_pct);
        in_item_t op;
        if ($urandom_range(99) < 3)
            op.cmd = CMD_UNUSED;
        else if ($urandom_range(99) < insert_pct)
            op.cmd = CMD_INSERT;
        else
            op.cmd = $urandom_range(1) ? CMD_REMOVE_MAX : CMD_REMOVE_MIN;
        case ($urandom_range(3))
            0:       op.prio_in = 16'($urandom_range(8)) - 16'd4;
            1:       op.prio_in = $urandom_range(1) ? 16'sh8000 : 16'sh7FFF;
            default: op.prio_in = 16'($urandom);
        endcase
        op.tag_in = ($urandom_range(99) < 5) ? 16'd0 : 16'($urandom_range(65535, 1));
        return op;
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic add_row(input in_item_t stim, input bit typed, input out_item_t want);
        queue_row_t row;
        row.stim  = stim;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    task automatic send_item(input in_item_t op, input bit typed, input out_item_t want);
        out_item_t predicted;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= op;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        predicted = sorted_queue_step(op);
        expected_results.push_back(typed ? want : predicted);
        sent_count++;
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        bit hold_taken;
        hold_taken = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                m_ready    <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin : check_results
        out_item_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            results_checked++;
            if (expected_results.size() == 0) begin
                report_error($sformatf("unexpected result %h", m_data));
            end else begin
                want = expected_results.pop_front();
                if (m_data.tag_out !== want.tag_out)
                    report_error($sformatf("tag_out %h, want %h", m_data.tag_out, want.tag_out));
                if (m_data.prio_out !== want.prio_out)
                    report_error($sformatf("prio_out %0d, want %0d",
                                           m_data.prio_out, want.prio_out));
                if (m_data.status !== want.status)
                    report_error($sformatf("status %0d, want %0d", m_data.status, want.status));
                if (m_data.fill_level !== want.fill_level)
                    report_error($sformatf("fill_level %0d, want %0d",
                                           m_data.fill_level, want.fill_level));
            end
        end
    end

    // watchdog: end the run when nothing moves for too long
    initial begin
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("** sorted_double_ended_priority_queue_unit: FAILED **");
        $finish;
    end

    initial begin
        in_item_t op;
        int       counted;
        int       insert_pct;
        int       burst;

        add_row('{CMD_REMOVE_MAX, 16'sd0, 16'd0}, 1'b1, '{16'd0, 16'sd0, STAT_EMPTY, 5'd0});
        add_row('{CMD_REMOVE_MIN, 16'sd0, 16'd0}, 1'b1, '{16'd0, 16'sd0, STAT_EMPTY, 5'd0});
        add_row('{CMD_INSERT, 16'sd100, 16'd0}, 1'b1, '{16'd0, 16'sd0, STAT_NULL_TAG, 5'd0});
        add_row('{CMD_UNUSED, 16'sd5, 16'd7}, 1'b1, '{16'd0, 16'sd0, STAT_OK, 5'd0});
        add_row('{CMD_INSERT, 16'sd0, 16'd1}, 1'b1, '{16'd0, 16'sd0, STAT_OK, 5'd1});
        add_row('{CMD_INSERT, 16'sh7FFF, 16'hFFFF}, 1'b1, '{16'd0, 16'sd0, STAT_OK, 5'd2});
        add_row('{CMD_INSERT, 16'sh8000, 16'h8000}, 1'b1, '{16'd0, 16'sd0, STAT_OK, 5'd3});
        add_row('{CMD_INSERT, 16'sd0, 16'd2}, 1'b0, '0);
        add_row('{CMD_INSERT, 16'sh7FFF, 16'd3}, 1'b0, '0);
        add_row('{CMD_INSERT, -16'sd1, 16'h5555}, 1'b0, '0);
        add_row('{CMD_INSERT, 16'sd1, 16'hAAAA}, 1'b0, '0);
        add_row('{CMD_INSERT, 16'sh8000, 16'd4}, 1'b0, '0);
        add_row('{CMD_INSERT, 16'sd0, 16'd0}, 1'b0, '0);
        add_row('{CMD_UNUSED, 16'shFFFF, 16'hFFFF}, 1'b0, '0);
        add_row('{CMD_REMOVE_MAX, 16'sd0, 16'd0}, 1'b0, '0);
        add_row('{CMD_REMOVE_MIN, 16'sd0, 16'd0}, 1'b0, '0);
        add_row('{CMD_REMOVE_MIN, 16'sd0, 16'd0}, 1'b0, '0);
        add_row('{CMD_REMOVE_MAX, 16'sd0, 16'd0}, 1'b0, '0);
        add_row('{CMD_REMOVE_MIN, 16'sd0, 16'd0}, 1'b0, '0);
        add_row('{CMD_REMOVE_MAX, 16'sd0, 16'd0}, 1'b0, '0);
        add_row('{CMD_REMOVE_MIN, 16'sd0, 16'd0}, 1'b0, '0);
        add_row('{CMD_REMOVE_MAX, 16'sd0, 16'd0}, 1'b0, '0);
        add_row('{CMD_REMOVE_MIN, 16'sd0, 16'd0}, 1'b1, '{16'd0, 16'sd0, STAT_EMPTY, 5'd0});
        add_row('{CMD_INSERT, 16'sh8000, 16'd1}, 1'b1, '{16'd0, 16'sd0, STAT_OK, 5'd1});
        add_row('{CMD_REMOVE_MAX, 16'sd0, 16'd0}, 1'b1, '{16'd1, 16'sh8000, STAT_OK, 5'd0});

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 6;
        rx_idle_pct = 60;
        foreach (directed_rows[i])
            send_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
        wait_for_drain();

        counted = 0;
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 60 : 0;
            rx_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 6 : 0;
            if (phase == 2)
                hold_request <= 1'b1;
            while (counted < (phase + 1) * RANDOM_ITEMS / 3) begin
                case ($urandom_range(2))
                    0:       insert_pct = 90;
                    1:       insert_pct = 10;
                    default: insert_pct = 50;
                endcase
                burst = $urandom_range(40, 8);
                if (burst > (phase + 1) * RANDOM_ITEMS / 3 - counted)
                    burst = (phase + 1) * RANDOM_ITEMS / 3 - counted;
                repeat (burst) begin
                    op = random_queue_op(insert_pct);
                    send_item(op, 1'b0, '0);
                    counted++;
                end
            end
            // hold off until every result is back
            wait_for_drain();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Ran %0d transactions (%0d directed), checked %0d results.",
                 sent_count, directed_rows.size(), results_checked);
        $display("Inserts into a full queue: %0d, removals from empty: %0d, null tags: %0d.",
                 full_rejects, empty_removes, null_tags);
        if (error_count == 0)
            $display("** sorted_double_ended_priority_queue_unit: PASSED **");
        else
            $display("** sorted_double_ended_priority_queue_unit: FAILED **");
        $finish;
    end

endmodule

>>> sorted_double_ended_priority_queue_unit.f
rtl/core/sdepq_pkg.sv
rtl/core/sdepq_dp.sv
rtl/core/sdepq_ctrl.sv
rtl/core/sorted_double_ended_priority_queue_unit.sv
tb/sorted_double_ended_priority_queue_unit_test.sv
